// ===== src/efg_pkg.sv =====
// Package for the event flag group: operation and result codes, waiter entry type.
// Depends on nothing; imported by every module of the block.
package efg_pkg;

	localparam int unsigned MaskBits   = 32;
	localparam int unsigned SlotsDflt  = 16;
	localparam int unsigned IdBitsDflt = 8;

	typedef enum logic [1:0] {
		FN_SEND  = 2'd0,
		FN_RECV  = 2'd1,
		FN_RESET = 2'd2,
		FN_SPARE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DONE   = 3'd0,
		ST_BAD    = 3'd1,
		ST_WOKEN  = 3'd2,
		ST_SAT    = 3'd3,
		ST_NOWAIT = 3'd4,
		ST_SUSP   = 3'd5,
		ST_FULL   = 3'd6,
		ST_RSTWK  = 3'd7
	} status_t;

	typedef enum logic {
		FS_IDLE,
		FS_WALK
	} fsm_t;

	// One waiter without its owner id (owner width follows a parameter).
	typedef struct packed {
		logic [MaskBits-1:0] mask;
		logic                all;
		logic                clr;
	} wentry_t;

endpackage

// ===== src/efg_cell.sv =====
// One waiter cell of the queue chain: holds an entry, takes its neighbour's on a shift.
// Depends on efg_pkg.
module efg_cell
	import efg_pkg::*;
#(
	parameter int unsigned ID_BITS = IdBitsDflt
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sh,
	input  logic               ld,
	input  wentry_t            nb_ent,
	input  logic [ID_BITS-1:0] nb_own,
	input  wentry_t            ld_ent,
	input  logic [ID_BITS-1:0] ld_own,
	output wentry_t            ent,
	output logic [ID_BITS-1:0] own
);

	wentry_t            ent_q;
	logic [ID_BITS-1:0] own_q;

	// payload only: occupancy is tracked by the fill count in the top level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			own_q <= '0;
		end else if (ld) begin
			ent_q <= ld_ent;
			own_q <= ld_own;
		end else if (sh) begin
			ent_q <= nb_ent;
			own_q <= nb_own;
		end
	end

	assign ent = ent_q;
	assign own = own_q;

endmodule

// ===== src/event_flag_group_waiters_top.sv =====
// Event flag group top level: event word, FIFO chain of waiter cells, control.
// Depends on efg_pkg and efg_cell.
//
// Use:
//  Input channel (in_valid / in_stall) carries one operation per transfer:
//  send bits, receive request or group reset. Output channel (out_valid /
//  out_stall) carries result transfers; last marks the final one per item.
//  Receive and malformed items give one result, in the cycle after the transfer.
//  Send and reset walk the waiter chain, visiting each queued waiter in
//  turn, head first, and then give the done result; one item is in work
//  at a time. in_stall stays high during a walk and while a stalled
//  result holds the output register, so the next item can transfer in the
//  cycle its predecessor's last result transfers out. A stall on the output
//  holds the register and the walk pauses at the next waiter that produces
//  a result. Reset (arst_n low) empties the queue and zeroes the event word
//  at once. Queue order: valid waiters sit packed from cell 0, oldest first.
//  During a walk the head is popped each cycle unless a stalled result
//  holds the output register; a waiter that stays is appended at the tail
//  of the packed region, so after the walk the order is unchanged.
module event_flag_group_waiters_top
	import efg_pkg::*;
#(
	parameter int unsigned WAITER_SLOTS = SlotsDflt,
	parameter int unsigned ID_BITS      = IdBitsDflt
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [31:0]         event_mask,
	input  logic                and_mode,
	input  logic                clear_on_take,
	input  logic                block_allowed,
	input  logic [ID_BITS-1:0]  requester_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [ID_BITS-1:0]  waiter_id,
	output logic [31:0]         received_bits,
	output logic                last
);

	localparam int unsigned LW = $clog2(WAITER_SLOTS + 1);

	fsm_t               state_q, state_d;
	logic [31:0]        word_q, word_d;
	logic [LW-1:0]      len_q, len_d, rem_q, rem_d;
	logic               rstw_q, rstw_d;
	logic               ovld_q, ovld_d;
	status_t            ost_q, ost_d;
	logic [ID_BITS-1:0] oid_q, oid_d;
	logic [31:0]        obits_q, obits_d;
	logic               olast_q, olast_d;

	wentry_t            ent_w [WAITER_SLOTS+1];
	logic [ID_BITS-1:0] own_w [WAITER_SLOTS+1];
	wentry_t            ld_ent;
	logic [ID_BITS-1:0] ld_own;
	logic               step, keep, enq;
	logic               out_free, accept, hit;
	logic [31:0]        got;
	func_t              fn;

	assign ent_w[WAITER_SLOTS] = '0;
	assign own_w[WAITER_SLOTS] = '0;

	assign fn       = func_t'(func);
	assign out_free = !ovld_q || !out_stall;
	assign in_stall = !(state_q == FS_IDLE && out_free);
	assign accept   = in_valid && !in_stall;

	// test the head waiter against the running word
	always_comb begin
		if (ent_w[0].all) begin
			got = ent_w[0].mask;
			hit = (ent_w[0].mask & word_q) == ent_w[0].mask;
		end else begin
			got = ent_w[0].mask & word_q;
			hit = got != '0;
		end
		if (rstw_q) begin
			hit = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		word_d  = word_q;
		len_d   = len_q;
		rem_d   = rem_q;
		rstw_d  = rstw_q;
		ovld_d  = ovld_q && out_stall;
		ost_d   = ost_q;
		oid_d   = oid_q;
		obits_d = obits_q;
		olast_d = olast_q;
		step    = 1'b0;
		keep    = 1'b0;
		enq     = 1'b0;
		ld_ent  = ent_w[0];
		ld_own  = own_w[0];
		case (state_q)
			FS_IDLE: begin
				if (accept) begin
					ovld_d  = 1'b1;
					oid_d   = '0;
					obits_d = '0;
					olast_d = 1'b1;
					if (fn == FN_SPARE || (fn != FN_RESET && event_mask == '0)) begin
						ost_d = ST_BAD;
					end else if (fn == FN_SEND) begin
						ovld_d  = 1'b0;
						word_d  = word_q | event_mask;
						rem_d   = len_q;
						rstw_d  = 1'b0;
						state_d = FS_WALK;
					end else if (fn == FN_RESET) begin
						ovld_d  = 1'b0;
						rem_d   = len_q;
						rstw_d  = 1'b1;
						state_d = FS_WALK;
					end else begin
						oid_d = requester_id;
						if (and_mode ? ((word_q & event_mask) == event_mask)
								: ((word_q & event_mask) != '0)) begin
							ost_d   = ST_SAT;
							obits_d = word_q & event_mask;
							if (clear_on_take) begin
								word_d = word_q & ~event_mask;
							end
						end else if (!block_allowed) begin
							ost_d = ST_NOWAIT;
						end else if (len_q == LW'(WAITER_SLOTS)) begin
							ost_d = ST_FULL;
						end else begin
							// append the new waiter at the tail
							ost_d      = ST_SUSP;
							enq        = 1'b1;
							ld_ent     = '{mask: event_mask, all: and_mode, clr: clear_on_take};
							ld_own     = requester_id;
							len_d      = len_q + LW'(1);
						end
					end
				end
			end
			FS_WALK: begin
				if (rem_q == '0) begin
					if (out_free) begin
						ovld_d  = 1'b1;
						ost_d   = ST_DONE;
						oid_d   = '0;
						obits_d = '0;
						olast_d = 1'b1;
						if (rstw_q) begin
							word_d = '0;
						end
						state_d = FS_IDLE;
					end
				end else if (!hit) begin
					// rotate the head to the tail; no result
					step  = 1'b1;
					keep  = 1'b1;
					rem_d = rem_q - LW'(1);
				end else if (out_free) begin
					// drop the head and report it
					step    = 1'b1;
					rem_d   = rem_q - LW'(1);
					len_d   = len_q - LW'(1);
					ovld_d  = 1'b1;
					oid_d   = own_w[0];
					olast_d = 1'b0;
					if (rstw_q) begin
						ost_d   = ST_RSTWK;
						obits_d = '0;
					end else begin
						ost_d   = ST_WOKEN;
						obits_d = got;
						if (ent_w[0].clr) begin
							word_d = word_q & ~got;
						end
					end
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			word_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			rstw_q  <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			rstw_q  <= rstw_d;
			ovld_q  <= ovld_d;
		end
	end

	always_ff @(posedge clk) begin
		ost_q   <= ost_d;
		oid_q   <= oid_d;
		obits_q <= obits_d;
		olast_q <= olast_d;
	end

	// the chain of waiter cells, cell 0 the oldest
	for (genvar i = 0; i < WAITER_SLOTS; i++) begin : g_cell
		logic cell_ld;
		assign cell_ld = (step && keep && len_q == LW'(i + 1)) ||
				(enq && len_q == LW'(i));
		efg_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.sh     (step),
			.ld     (cell_ld),
			.nb_ent (ent_w[i+1]),
			.nb_own (own_w[i+1]),
			.ld_ent (ld_ent),
			.ld_own (ld_own),
			.ent    (ent_w[i]),
			.own    (own_w[i])
		);
	end

	assign out_valid     = ovld_q;
	assign status        = ost_q;
	assign waiter_id     = oid_q;
	assign received_bits = obits_q;
	assign last          = olast_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(WAITER_SLOTS))
		else $error("waiter count beyond slot count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FS_WALK |-> rem_q <= len_q)
		else $error("walk count beyond waiter count");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FS_WALK && rem_q == '0 && out_free |=>
			state_q == FS_IDLE && out_valid && last)
		else $error("walk did not end with a last result");

	a_bits_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && received_bits != '0 |-> status == ST_WOKEN || status == ST_SAT)
		else $error("bits delivered in a result that carries none");

endmodule

// ===== verif/event_flag_group_waiters_top_tb.sv =====
// Testbench for event_flag_group_waiters_top: directed and random send, receive and
// group reset operations, checked against a behavioural predictor held in a scoreboard.
// Depends on efg_pkg and the block's RTL.
module event_flag_group_waiters_top_tb;
	import efg_pkg::*;

	localparam int Slots = 16;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  who;
		logic [31:0] bits;
		logic        last;
	} result_t;

	// Flag group model and queue of results still owed by the block.
	class flag_group_board;
		logic [31:0] word;
		// Waiters kept in arrival order, oldest at index 0.
		logic [31:0] w_mask[$];
		logic        w_all[$];
		logic        w_clr[$];
		logic [7:0]  w_who[$];
		result_t     owed[$];
		int          errors;
		int          checked;
		int          wakes;

		function void clear();
			word = '0;
			w_mask.delete();
			w_all.delete();
			w_clr.delete();
			w_who.delete();
			owed.delete();
		endfunction

		function void owe(status_t s, logic [7:0] who, logic [31:0] bits, logic lst);
			result_t r;
			r.status = s;
			r.who = who;
			r.bits = bits;
			r.last = lst;
			owed.push_back(r);
		endfunction

		function int waiting();
			return w_mask.size();
		endfunction

		// Note an accepted transfer on the input side and work out its results.
		function void note_op(logic [1:0] fn, logic [31:0] m, logic a, logic c, logic b,
				logic [7:0] id);
			logic [31:0] got;
			logic hit;
			int i;
			if (fn == FN_SPARE || (fn != FN_RESET && m == '0)) begin
				owe(ST_BAD, 8'd0, '0, 1'b1);
			end else if (fn == FN_SEND) begin
				word |= m;
				i = 0;
				while (i < w_mask.size()) begin
					if (w_all[i]) begin
						got = w_mask[i];
						hit = (w_mask[i] & word) == w_mask[i];
					end else begin
						got = w_mask[i] & word;
						hit = got != '0;
					end
					if (hit) begin
						if (w_clr[i])
							word &= ~got;
						owe(ST_WOKEN, w_who[i], got, 1'b0);
						wakes++;
						w_mask.delete(i);
						w_all.delete(i);
						w_clr.delete(i);
						w_who.delete(i);
					end else begin
						i++;
					end
				end
				owe(ST_DONE, 8'd0, '0, 1'b1);
			end else if (fn == FN_RESET) begin
				foreach (w_who[k])
					owe(ST_RSTWK, w_who[k], '0, 1'b0);
				w_mask.delete();
				w_all.delete();
				w_clr.delete();
				w_who.delete();
				word = '0;
				owe(ST_DONE, 8'd0, '0, 1'b1);
			end else begin
				hit = a ? ((word & m) == m) : ((word & m) != '0);
				if (hit) begin
					got = word & m;
					if (c)
						word &= ~m;
					owe(ST_SAT, id, got, 1'b1);
				end else if (!b) begin
					owe(ST_NOWAIT, id, '0, 1'b1);
				end else if (w_mask.size() >= Slots) begin
					owe(ST_FULL, id, '0, 1'b1);
				end else begin
					w_mask.push_back(m);
					w_all.push_back(a);
					w_clr.push_back(c);
					w_who.push_back(id);
					owe(ST_SUSP, id, '0, 1'b1);
				end
			end
		endfunction

		// Compare one result transfer with the oldest expectation.
		function void check(result_t got);
			result_t exp;
			checked++;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result status=%0d id=%0d bits=%h last=%0d",
					$time, got.status, got.who, got.bits, got.last);
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (got.status != exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.who != exp.who) begin
				$display("%0t: waiter_id expected %0d actual %0d", $time, exp.who, got.who);
				errors++;
			end
			if (got.bits != exp.bits) begin
				$display("%0t: received_bits expected %h actual %h", $time, exp.bits,
					got.bits);
				errors++;
			end
			if (got.last != exp.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FN_SEND;
	logic [31:0] event_mask = '0;
	logic        and_mode = 1'b0;
	logic        clear_on_take = 1'b0;
	logic        block_allowed = 1'b0;
	logic [7:0]  requester_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  waiter_id;
	logic [31:0] received_bits;
	logic        last;

	flag_group_board board = new();
	bit calm = 0;        // no idling in the closing stretch
	bit hold_off = 0;    // long receiver stall requested by the sender process
	int sent = 0;

	always #5 clk = ~clk;

	event_flag_group_waiters_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .event_mask(event_mask), .and_mode(and_mode),
		.clear_on_take(clear_on_take), .block_allowed(block_allowed),
		.requester_id(requester_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .waiter_id(waiter_id), .received_bits(received_bits),
		.last(last)
	);

	// Note each transfer as it happens, on both sides.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_op(func, event_mask, and_mode, clear_on_take, block_allowed,
				requester_id);
		if (arst_n && out_valid && !out_stall)
			board.check('{status, waiter_id, received_bits, last});
	end

	// Receiver: random stall bursts, a long hold-off on request, none at the end.
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(3) == 0) begin
				n = $urandom_range(16, 1);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(12, 1)) @(posedge clk);
			end
		end
	end

	// Offer one operation and hold it until it transfers; optionally idle first.
	task automatic offer(logic [1:0] fn, logic [31:0] m, logic a, logic c, logic b,
			logic [7:0] id);
		if (!calm && $urandom_range(4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		event_mask <= m;
		and_mode <= a;
		clear_on_take <= c;
		block_allowed <= b;
		requester_id <= id;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Masks built mostly from one byte, the lowest or the highest, so that waiters meet each other.
	function automatic logic [31:0] pick_mask();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000 >> $urandom_range(3);
			default: return $urandom_range(255, 1) << ($urandom_range(1) * 24);
		endcase
	endfunction

	task automatic random_op();
		int          pick;
		logic [31:0] r;
		logic        a;
		logic        c;
		logic        b;
		logic [7:0]  id;
		pick = $urandom_range(99);
		r = $urandom();
		a = 1'($urandom());
		c = 1'($urandom());
		b = 1'($urandom());
		id = 8'($urandom());
		if (pick < 3)
			offer(FN_SPARE, r, a, c, b, id);
		else if (pick < 6)
			offer(FN_RESET, r, a, c, b, id);
		else if (pick < 9)
			offer(2'($urandom_range(1)), 32'd0, a, c, b, id);
		else if (pick < 40)
			offer(FN_SEND, pick_mask(), a, c, b, id);
		else
			offer(FN_RECV, pick_mask(), a, c, $urandom_range(7) != 0, id);
	endtask

	initial begin : sender
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad masks, spare code, satisfied, no-wait, fill and overfill the
		// table, wake by send, all-bits and clearing waiters, group reset.
		offer(FN_SEND, 32'd0, 1'b1, 1'b1, 1'b1, 8'hFF);
		offer(FN_RECV, 32'd0, 1'b0, 1'b0, 1'b1, 8'h01);
		offer(FN_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF);
		offer(FN_SEND, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 8'h00);
		offer(FN_RECV, 32'h0000_0003, 1'b0, 1'b1, 1'b0, 8'h10);
		offer(FN_RECV, 32'h0000_0003, 1'b1, 1'b0, 1'b0, 8'h11);
		offer(FN_RECV, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF);
		offer(FN_RECV, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 8'h00);
		offer(FN_RECV, 32'h8000_0001, 1'b0, 1'b0, 1'b1, 8'h5A);
		for (i = 0; i < 14; i++)
			offer(FN_RECV, 32'h1 << (i + 4), i[0], i[1], 1'b1, 8'h20 + 8'(i));
		offer(FN_RECV, 32'h2, 1'b0, 1'b0, 1'b1, 8'hA5);
		offer(FN_SEND, 32'h8000_00F0, 1'b0, 1'b0, 1'b0, 8'h00);
		offer(FN_RESET, 32'h0, 1'b0, 1'b0, 1'b0, 8'h00);
		offer(FN_SEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00);

		// Random, with one long receiver hold-off while items keep coming.
		for (i = 0; i < 230; i++) begin
			if (i == 60)
				hold_off = 1;
			if (i == 200)
				calm = 1;
			random_op();
		end
		in_valid <= 1'b0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d items, %0d results checked, %0d waiters woken by send.",
			sent, board.checked, board.wakes);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Timed out with %0d results outstanding.", board.owed.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
